// ===== rtl/core/stc_pkg.sv =====
`timescale 1ns / 1ps
package stc_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int ANGLE_STAGES = 20;
   localparam int PRE_SHIFT    = 26;

   // Vector width inside the angle pipeline and width of its angle word (pi = 2^31).
   localparam int CW = 62;
   localparam int ZW = 34;

   // Radicand width of the square root pipeline; one result bit per stage.
   localparam int SQW       = 62;
   localparam int SQ_STAGES = SQW / 2;

   localparam int CORDIC_LAT = ANGLE_STAGES + 1;
   localparam int META_LEN   = SQ_STAGES + CORDIC_LAT + 1;
   localparam int PL_LEN     = META_LEN - 3;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   localparam logic [1:0] KIND_SPHERE = 2'd0;
   localparam logic [1:0] KIND_PLANE  = 2'd1;

   localparam logic signed [ZW-1:0] ANG_PI = ZW'(64'sh8000_0000);

   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};

   typedef struct packed {
      logic [1:0]         kind;
      logic               kind_err;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dz;
      logic signed [17:0] nx;
      logic signed [17:0] ny;
      logic signed [17:0] nz;
      logic [30:0]        radius;
   } item_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic               kind_err;
      logic               v_zero;
      logic               v_one;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dz;
   } meta_type;

   typedef struct packed {
      logic signed [31:0] pu;
      logic signed [31:0] pv;
   } plane_type;

endpackage

// ===== rtl/core/stc_front.sv =====
`timescale 1ns / 1ps
module stc_front import stc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_hit_x,
   input  logic signed [31:0] req_hit_y,
   input  logic signed [31:0] req_hit_z,
   input  logic signed [31:0] req_ref_x,
   input  logic signed [31:0] req_ref_y,
   input  logic signed [31:0] req_ref_z,
   input  logic signed [17:0] req_normal_x,
   input  logic signed [17:0] req_normal_y,
   input  logic signed [17:0] req_normal_z,
   input  logic [30:0]        req_radius,
   output logic               out_valid,
   input  logic               out_ready,
   output item_type           out_item
);

   logic     vld_ff, vld_in;
   item_type item_ff, item_in;
   logic     take;

   assign req_ready = !vld_ff || out_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      item_in          = item_ff;
      vld_in           = vld_ff && !out_ready;
      if (take) begin
         vld_in          = 1'b1;
         item_in.kind    = req_operation;
         item_in.kind_err = (req_operation != KIND_SPHERE) && (req_operation != KIND_PLANE);
         item_in.dx      = 33'(req_hit_x) - 33'(req_ref_x);
         item_in.dy      = 33'(req_hit_y) - 33'(req_ref_y);
         item_in.dz      = 33'(req_hit_z) - 33'(req_ref_z);
         item_in.nx      = req_normal_x;
         item_in.ny      = req_normal_y;
         item_in.nz      = req_normal_z;
         item_in.radius  = req_radius;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = vld_ff;
   assign out_item  = item_ff;

endmodule

// ===== rtl/core/stc_fifo.sv =====
`timescale 1ns / 1ps
module stc_fifo import stc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_AW:0]     cnt_ff, cnt_in;
   logic                 push, pop;

   assign push_ready = cnt_ff != (FIFO_AW+1)'(FIFO_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_item   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/core/stc_cordic.sv =====
`timescale 1ns / 1ps
module stc_cordic import stc_pkg::*; (
   input  logic                 clock,
   input  logic                 enable,
   input  logic signed [CW-1:0] vec_y,
   input  logic signed [CW-1:0] vec_x,
   output logic signed [ZW-1:0] angle
);

   logic signed [CW-1:0] x_ff [0:ANGLE_STAGES];
   logic signed [CW-1:0] y_ff [0:ANGLE_STAGES];
   logic signed [ZW-1:0] z_ff [0:ANGLE_STAGES];
   logic                 zero_ff [0:ANGLE_STAGES];

   logic signed [CW-1:0] x0_in, y0_in;
   logic signed [ZW-1:0] z0_in;
   logic                 zero0_in;

   // Vectors in the left half plane are turned by 180 degrees first.
   always_comb begin
      zero0_in = (vec_x == '0) && (vec_y == '0);
      if (vec_x < 0) begin
         x0_in = -vec_x;
         y0_in = -vec_y;
         z0_in = (vec_y >= 0) ? ANG_PI : -ANG_PI;
      end else begin
         x0_in = vec_x;
         y0_in = vec_y;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         zero_ff[0] <= zero0_in;
      end
   end

   for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_stage
      logic signed [CW-1:0] xs_in, ys_in;
      logic signed [ZW-1:0] zs_in;

      always_comb begin
         if (y_ff[i] > 0) begin
            xs_in = x_ff[i] + (y_ff[i] >>> i);
            ys_in = y_ff[i] - (x_ff[i] >>> i);
            zs_in = z_ff[i] + ZW'(ATAN_TAB[i]);
         end else begin
            xs_in = x_ff[i] - (y_ff[i] >>> i);
            ys_in = y_ff[i] + (x_ff[i] >>> i);
            zs_in = z_ff[i] - ZW'(ATAN_TAB[i]);
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            x_ff[i+1]    <= xs_in;
            y_ff[i+1]    <= ys_in;
            z_ff[i+1]    <= zs_in;
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   always_comb begin
      if (zero_ff[ANGLE_STAGES]) begin
         angle = '0;
      end else if (z_ff[ANGLE_STAGES] > ANG_PI) begin
         angle = ANG_PI;
      end else if (z_ff[ANGLE_STAGES] < -ANG_PI) begin
         angle = -ANG_PI;
      end else begin
         angle = z_ff[ANGLE_STAGES];
      end
   end

endmodule

// ===== rtl/core/stc_isqrt.sv =====
`timescale 1ns / 1ps
module stc_isqrt import stc_pkg::*; (
   input  logic               clock,
   input  logic               enable,
   input  logic [SQW-1:0]     radicand,
   output logic [SQ_STAGES:0] root
);

   logic [SQW-1:0] n_ff [SQ_STAGES];
   logic [SQW-1:0] r_ff [SQ_STAGES];

   for (genvar k = 0; k < SQ_STAGES; k++) begin : g_step
      localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STAGES - 1 - k));
      logic [SQW-1:0] n_prev, r_prev, trial, n_in, r_in;

      if (k == 0) begin : g_first
         assign n_prev = radicand;
         assign r_prev = '0;
      end else begin : g_next
         assign n_prev = n_ff[k-1];
         assign r_prev = r_ff[k-1];
      end

      always_comb begin
         trial = r_prev + BIT;
         if (n_prev >= trial) begin
            n_in = n_prev - trial;
            r_in = (r_prev >> 1) + BIT;
         end else begin
            n_in = n_prev;
            r_in = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            n_ff[k] <= n_in;
            r_ff[k] <= r_in;
         end
      end
   end

   assign root = r_ff[SQ_STAGES-1][SQ_STAGES:0];

endmodule

// ===== rtl/core/stc_back.sv =====
`timescale 1ns / 1ps
module stc_back import stc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  item_type           in_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_coord_u,
   output logic signed [31:0] rsp_coord_v,
   output logic               rsp_kind_error
);

   logic adv;

   // Stage one: the word taken from the queue.
   logic     s1_vld_ff;
   item_type s1_ff;

   // Delay line of control and difference vector, index 0 is stage two.
   logic     vld_ff  [META_LEN];
   meta_type meta_ff [META_LEN];
   meta_type meta_in;

   logic [SQW-1:0] r_sq_ff, dy_sq_ff;
   logic [32:0]    abs_dy;

   // Plane path.
   logic signed [18:0] xa_in [3];
   logic signed [18:0] xa_ff [3];
   logic signed [18:0] xa3_ff [3];
   logic signed [36:0] p_ff [6];
   logic signed [21:0] ya_ff [3];
   logic signed [55:0] q_ff [6];
   plane_type          pl_ff [PL_LEN];
   plane_type          pl_in;

   // Sphere path.
   logic [SQW-1:0]       radicand;
   logic [SQ_STAGES:0]   root;
   logic signed [CW-1:0] uy, ux, vy, vx;
   logic signed [ZW-1:0] ang_u, ang_v;

   // Output register.
   logic               out_vld_ff;
   logic signed [31:0] u_ff, v_ff, u_in, v_in;
   logic               err_ff, err_in;

   assign adv      = !out_vld_ff || rsp_ready;
   assign in_ready = adv;

   function automatic logic signed [31:0] sat32(input logic signed [57:0] x);
      if (x > 58'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end else if (x < -58'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return x[31:0];
      end
   endfunction

   always_comb begin
      abs_dy         = s1_ff.dy[32] ? 33'(-s1_ff.dy) : 33'(s1_ff.dy);
      meta_in.kind     = s1_ff.kind;
      meta_in.kind_err = s1_ff.kind_err;
      meta_in.dx       = s1_ff.dx;
      meta_in.dy       = s1_ff.dy;
      meta_in.dz       = s1_ff.dz;
      meta_in.v_zero   = 34'(s1_ff.dy) >= $signed({3'b0, s1_ff.radius});
      meta_in.v_one    = -34'(s1_ff.dy) >= $signed({3'b0, s1_ff.radius});
      // The x axis is normal cross z, or normal cross y when that vanishes.
      if (s1_ff.nx == '0 && s1_ff.ny == '0) begin
         xa_in[0] = -19'(s1_ff.nz);
         xa_in[1] = '0;
         xa_in[2] = 19'(s1_ff.nx);
      end else begin
         xa_in[0] = 19'(s1_ff.ny);
         xa_in[1] = -19'(s1_ff.nx);
         xa_in[2] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         for (int j = 0; j < META_LEN; j++) begin
            vld_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         s1_vld_ff <= in_valid;
         vld_ff[0] <= s1_vld_ff;
         for (int j = 1; j < META_LEN; j++) begin
            vld_ff[j] <= vld_ff[j-1];
         end
      end
      if (adv) begin
         s1_ff      <= in_item;
         meta_ff[0] <= meta_in;
         for (int j = 1; j < META_LEN; j++) begin
            meta_ff[j] <= meta_ff[j-1];
         end
         r_sq_ff  <= SQW'(s1_ff.radius) * SQW'(s1_ff.radius);
         dy_sq_ff <= SQW'(abs_dy[30:0]) * SQW'(abs_dy[30:0]);
         for (int j = 0; j < 3; j++) begin
            xa_ff[j] <= xa_in[j];
         end
         p_ff[0] <= s1_ff.ny * xa_in[2];
         p_ff[1] <= s1_ff.nz * xa_in[1];
         p_ff[2] <= s1_ff.nz * xa_in[0];
         p_ff[3] <= s1_ff.nx * xa_in[2];
         p_ff[4] <= s1_ff.nx * xa_in[1];
         p_ff[5] <= s1_ff.ny * xa_in[0];
      end
   end

   // Plane: y axis rounded to the fraction, then dot products, rounded and saturated.
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 3; j++) begin
            ya_ff[j]  <= 22'((38'(p_ff[2*j]) - 38'(p_ff[2*j+1])
                         + (38'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
            xa3_ff[j] <= xa_ff[j];
         end
         q_ff[0] <= meta_ff[1].dx * xa3_ff[0];
         q_ff[1] <= meta_ff[1].dy * xa3_ff[1];
         q_ff[2] <= meta_ff[1].dz * xa3_ff[2];
         q_ff[3] <= meta_ff[1].dx * ya_ff[0];
         q_ff[4] <= meta_ff[1].dy * ya_ff[1];
         q_ff[5] <= meta_ff[1].dz * ya_ff[2];
         pl_ff[0] <= pl_in;
         for (int j = 1; j < PL_LEN; j++) begin
            pl_ff[j] <= pl_ff[j-1];
         end
      end
   end

   always_comb begin
      pl_in.pu = sat32((58'(q_ff[0]) + 58'(q_ff[1]) + 58'(q_ff[2])
                 + (58'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      pl_in.pv = sat32((58'(q_ff[3]) + 58'(q_ff[4]) + 58'(q_ff[5])
                 + (58'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
   end

   // Sphere: v is acos(dy/R) taken as atan2(sqrt(R^2 - dy^2), dy).
   assign radicand = (meta_ff[0].v_zero || meta_ff[0].v_one) ? '0 : r_sq_ff - dy_sq_ff;

   stc_isqrt u_isqrt (
      .clock    (clock),
      .enable   (adv),
      .radicand (radicand),
      .root     (root)
   );

   assign uy = CW'(meta_ff[SQ_STAGES].dz) <<< PRE_SHIFT;
   assign ux = CW'(meta_ff[SQ_STAGES].dx) <<< PRE_SHIFT;
   assign vy = signed'(CW'({root, PRE_SHIFT'(0)}));
   assign vx = CW'(meta_ff[SQ_STAGES].dy) <<< PRE_SHIFT;

   stc_cordic u_cordic_u (
      .clock  (clock),
      .enable (adv),
      .vec_y  (uy),
      .vec_x  (ux),
      .angle  (ang_u)
   );

   stc_cordic u_cordic_v (
      .clock  (clock),
      .enable (adv),
      .vec_y  (vy),
      .vec_x  (vx),
      .angle  (ang_v)
   );

   always_comb begin
      logic signed [ZW+1:0] u_sum, v_sum;
      meta_type             m;
      m     = meta_ff[META_LEN-1];
      u_sum = (ZW+2)'(ANG_PI) + (ZW+2)'(ang_u) + ((ZW+2)'(1) <<< (31 - FRAC_BITS));
      v_sum = (ang_v < 0) ? (ZW+2)'(0) : (ZW+2)'(ang_v);
      v_sum = v_sum + ((ZW+2)'(1) <<< (30 - FRAC_BITS));
      err_in = m.kind_err;
      case (m.kind)
         KIND_SPHERE: begin
            u_in = 32'(u_sum >>> (32 - FRAC_BITS));
            if (m.v_zero) begin
               v_in = '0;
            end else if (m.v_one) begin
               v_in = 32'sd1 <<< FRAC_BITS;
            end else begin
               v_in = 32'(v_sum >>> (31 - FRAC_BITS));
            end
         end
         KIND_PLANE: begin
            u_in = pl_ff[PL_LEN-1].pu;
            v_in = pl_ff[PL_LEN-1].pv;
         end
         default: begin
            u_in = '0;
            v_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= vld_ff[META_LEN-1];
      end
      if (adv) begin
         u_ff   <= u_in;
         v_ff   <= v_in;
         err_ff <= err_in;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_coord_u    = u_ff;
   assign rsp_coord_v    = v_ff;
   assign rsp_kind_error = err_ff;

endmodule

// ===== rtl/core/surface_texture_coordinate.sv =====
`timescale 1ns / 1ps
// Texture coordinates for a hit on a sphere or a plane, signed Q16.16 in and out.
// The block takes one word per clock and returns one result word per clock for
// as long as the result side keeps taking them. Inside, a word passes through
// the input register and the queue, then a pipeline set by the 31-step square
// root followed by the 21-stage angle pipeline for acos, plus the output
// register. A stalled result side holds the whole back pipeline, and the
// four-word queue lets the input side keep going for a few words after that.
module surface_texture_coordinate import stc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_hit_x,
   input  logic signed [31:0] req_hit_y,
   input  logic signed [31:0] req_hit_z,
   input  logic signed [31:0] req_ref_x,
   input  logic signed [31:0] req_ref_y,
   input  logic signed [31:0] req_ref_z,
   input  logic signed [17:0] req_normal_x,
   input  logic signed [17:0] req_normal_y,
   input  logic signed [17:0] req_normal_z,
   input  logic [30:0]        req_radius,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_coord_u,
   output logic signed [31:0] rsp_coord_v,
   output logic               rsp_kind_error
);

   logic     f_valid, f_ready, q_valid, q_ready;
   item_type f_item, q_item;

   stc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_hit_x     (req_hit_x),
      .req_hit_y     (req_hit_y),
      .req_hit_z     (req_hit_z),
      .req_ref_x     (req_ref_x),
      .req_ref_y     (req_ref_y),
      .req_ref_z     (req_ref_z),
      .req_normal_x  (req_normal_x),
      .req_normal_y  (req_normal_y),
      .req_normal_z  (req_normal_z),
      .req_radius    (req_radius),
      .out_valid     (f_valid),
      .out_ready     (f_ready),
      .out_item      (f_item)
   );

   stc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_item  (f_item),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_item   (q_item)
   );

   stc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (q_valid),
      .in_ready       (q_ready),
      .in_item        (q_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_coord_u    (rsp_coord_u),
      .rsp_coord_v    (rsp_coord_v),
      .rsp_kind_error (rsp_kind_error)
   );

endmodule
